/* sv/ffes_pkg.sv */
// ----------------------------------------------------------------------------
// ffes_pkg
// Shared widths, types and constants for the frame field edge singularity
// block.
// ----------------------------------------------------------------------------
package ffes_pkg;

  localparam int FRAME_BITS = 16;
  localparam int PROD_BITS  = 2 * FRAME_BITS;
  // three products summed exactly
  localparam int DOT_BITS   = PROD_BITS + 2;

  typedef logic signed [FRAME_BITS-1:0] entry_t;
  typedef entry_t                       frame_t [0:8];
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [DOT_BITS-1:0]   dot_t;

  // Signed permutation by columns: column j maps to row row[j] with sign neg[j].
  typedef struct packed {
    logic [2:0][1:0] row;
    logic [2:0]      neg;
  } perm_t;

  localparam perm_t PERM_IDENT = '{row: {2'd2, 2'd1, 2'd0}, neg: 3'b000};

  // Per-item flags carried down the pipeline.
  typedef struct packed {
    logic first;
    logic last;
    logic bnd;
  } ctrl_t;

endpackage

/* sv/ffes_perm.sv */
// ----------------------------------------------------------------------------
// ffes_perm
// Three-stage transition unit: column dot products of two frames, exact
// sums, and per-column selection of the dominant row and its sign.
// ----------------------------------------------------------------------------
module ffes_perm (
  input  logic            clk,
  input  logic            en_prod,
  input  logic            en_sum,
  input  logic            en_sel,
  input  ffes_pkg::frame_t a,
  input  ffes_pkg::frame_t b,
  output ffes_pkg::perm_t  t
);
  import ffes_pkg::*;

  prod_t prod [0:2][0:2][0:2];
  dot_t  dot  [0:2][0:2];
  perm_t sel;

  function automatic logic [2:0] pick(input dot_t d0, input dot_t d1, input dot_t d2);
    logic [DOT_BITS-1:0] m0, m1, m2, mb;
    logic [1:0]          best;
    dot_t                db;
    logic                neg;
    m0 = d0[DOT_BITS-1] ? DOT_BITS'(-d0) : DOT_BITS'(d0);
    m1 = d1[DOT_BITS-1] ? DOT_BITS'(-d1) : DOT_BITS'(d1);
    m2 = d2[DOT_BITS-1] ? DOT_BITS'(-d2) : DOT_BITS'(d2);
    best = 2'd0;
    mb   = m0;
    db   = d0;
    // lowest index wins ties
    if (m1 > mb) begin
      best = 2'd1;
      mb   = m1;
      db   = d1;
    end
    if (m2 > mb) begin
      best = 2'd2;
      db   = d2;
    end
    neg = db[DOT_BITS-1] || (db == '0);
    return {neg, best};
  endfunction

  // column j of a against column i of b
  always_ff @(posedge clk) begin
    if (en_prod) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          for (int k = 0; k < 3; k++) begin
            prod[j][i][k] <= prod_t'(b[k*3+i]) * prod_t'(a[k*3+j]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          dot[j][i] <= dot_t'(prod[j][i][0]) + dot_t'(prod[j][i][1])
                     + dot_t'(prod[j][i][2]);
        end
      end
    end
  end

  always_comb begin
    logic [2:0] p;
    sel = PERM_IDENT;
    for (int j = 0; j < 3; j++) begin
      p = pick(dot[j][0], dot[j][1], dot[j][2]);
      sel.row[j] = p[1:0];
      sel.neg[j] = p[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en_sel) begin
      t <= sel;
    end
  end

endmodule

/* sv/ffes_mono.sv */
// ----------------------------------------------------------------------------
// ffes_mono
// Running monodromy held as a signed column permutation; folds in the step
// and closing transitions and registers the singularity flag.
// ----------------------------------------------------------------------------
module ffes_mono (
  input  logic            clk,
  input  logic            rst,
  input  logic            retire,
  input  ffes_pkg::ctrl_t ctrl,
  input  ffes_pkg::perm_t t_step,
  input  ffes_pkg::perm_t t_close,
  output logic            singular
);
  import ffes_pkg::*;

  perm_t mono;
  perm_t m_step;
  perm_t m_close;
  perm_t mono_next;
  logic  is_ident;

  // Compose T * M column by column: column j of M is +-e[row], T sends e[row] on.
  always_comb begin
    m_step = ctrl.first ? PERM_IDENT : mono;
    if (!ctrl.first) begin
      for (int j = 0; j < 3; j++) begin
        m_step.row[j] = t_step.row[mono.row[j]];
        m_step.neg[j] = mono.neg[j] ^ t_step.neg[mono.row[j]];
      end
    end
    m_close = m_step;
    for (int j = 0; j < 3; j++) begin
      m_close.row[j] = t_close.row[m_step.row[j]];
      m_close.neg[j] = m_step.neg[j] ^ t_close.neg[m_step.row[j]];
    end
    mono_next = ctrl.last ? m_close : m_step;
    is_ident  = (m_close == PERM_IDENT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mono <= PERM_IDENT;
    end else if (retire) begin
      mono <= mono_next;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && ctrl.last) begin
      singular <= !ctrl.bnd && !is_ident;
    end
  end

endmodule

/* sv/frame_field_edge_singularity.sv */
// ----------------------------------------------------------------------------
// frame_field_edge_singularity
// Octahedral frame field monodromy test around one mesh edge.
// ----------------------------------------------------------------------------
// Frames arrive one per request in ring order; ring_last closes the ring and
// produces one result. The block takes one frame per cycle while in_stall is
// low, and the result passes through the input register, product register,
// sum register, selection register and result register after the last frame
// is taken. The step transition (previous to current frame) and the closing
// transition (current to first frame) run in two parallel dot product units,
// and the running monodromy is updated as each frame leaves the selection
// stage. Only the boundary flag of the last frame counts.
module frame_field_edge_singularity (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ffes_pkg::entry_t         f00,
  input  ffes_pkg::entry_t         f01,
  input  ffes_pkg::entry_t         f02,
  input  ffes_pkg::entry_t         f10,
  input  ffes_pkg::entry_t         f11,
  input  ffes_pkg::entry_t         f12,
  input  ffes_pkg::entry_t         f20,
  input  ffes_pkg::entry_t         f21,
  input  ffes_pkg::entry_t         f22,
  input  logic                     ring_last,
  input  logic                     edge_on_boundary,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     singular
);
  import ffes_pkg::*;

  frame_t cur;
  frame_t prev_frame;
  frame_t first_frame;
  logic   ring_open;

  frame_t fa, fb, ff;
  ctrl_t  actl, bctl, cctl, dctl;
  logic   va, vb, vc, vd;
  logic   rdy_a, rdy_b, rdy_c, rdy_d;
  logic   out_free, accept, retire;
  perm_t  t_step, t_close;

  assign cur = '{entry_t'(f00), entry_t'(f01), entry_t'(f02),
                 entry_t'(f10), entry_t'(f11), entry_t'(f12),
                 entry_t'(f20), entry_t'(f21), entry_t'(f22)};

  // Non-last frames retire without the result register.
  assign out_free = !out_valid || !out_stall;
  assign rdy_d    = !vd || !dctl.last || out_free;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_stall = !rdy_a;
  assign accept   = in_valid && rdy_a;
  assign retire   = vd && rdy_d;

  // Ring bookkeeping at request time.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_open <= 1'b0;
    end else if (accept) begin
      ring_open <= !ring_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_frame <= cur;
      if (!ring_open) begin
        first_frame <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fa   <= prev_frame;
      fb   <= cur;
      ff   <= ring_open ? first_frame : cur;
      actl <= '{first: !ring_open, last: ring_last, bnd: edge_on_boundary};
    end
    if (va && rdy_b) begin
      bctl <= actl;
    end
    if (vb && rdy_c) begin
      cctl <= bctl;
    end
    if (vc && rdy_d) begin
      dctl <= cctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) begin
        va <= in_valid;
      end
      if (rdy_b) begin
        vb <= va;
      end
      if (rdy_c) begin
        vc <= vb;
      end
      if (rdy_d) begin
        vd <= vc;
      end
      if (retire && dctl.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  ffes_perm u_step (
    .clk     (clk),
    .en_prod (va && rdy_b),
    .en_sum  (vb && rdy_c),
    .en_sel  (vc && rdy_d),
    .a       (fa),
    .b       (fb),
    .t       (t_step)
  );

  ffes_perm u_close (
    .clk     (clk),
    .en_prod (va && rdy_b),
    .en_sum  (vb && rdy_c),
    .en_sel  (vc && rdy_d),
    .a       (fb),
    .b       (ff),
    .t       (t_close)
  );

  ffes_mono u_mono (
    .clk      (clk),
    .rst      (rst),
    .retire   (retire),
    .ctrl     (dctl),
    .t_step   (t_step),
    .t_close  (t_close),
    .singular (singular)
  );

`ifndef SYNTHESIS
  a_ring_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && ring_last) |=> !ring_open)
    else $error("ring still open after last frame");

  a_boundary_clear: assert property (@(posedge clk) disable iff (rst)
    (retire && dctl.last && dctl.bnd) |=> (out_valid && !singular))
    else $error("boundary edge flagged singular");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!va && !vb && !vc && !vd) |-> !in_stall)
    else $error("stall with empty pipeline");
`endif

endmodule
